// File: rtl/core/lsap_pkg.sv
// shared constants, payload types and the channel weight table of the line sensor array
package lsap_pkg;

   localparam int SENSOR_COUNT  = 13;
   localparam int SAMPLE_BITS   = 12;
   localparam int CH_BITS       = 4;
   localparam int RATIO_BITS    = 10;
   localparam int PROD_BITS     = SAMPLE_BITS + RATIO_BITS;
   localparam int DIV_CNT_BITS  = $clog2(RATIO_BITS + 1);
   localparam int WEIGHT_BITS   = 5;
   localparam int WPROD_BITS    = RATIO_BITS + WEIGHT_BITS;
   localparam int ERR_BITS      = 18;
   localparam int RUN_BITS      = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 10;

   localparam logic [RATIO_BITS-1:0]  RATIO_ONE    = RATIO_BITS'(1000);
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE   = {SAMPLE_BITS{1'b1}};
   localparam logic [CH_BITS-1:0]     LAST_CHANNEL = CH_BITS'(SENSOR_COUNT - 1);
   localparam logic [CH_BITS-1:0]     CENTER_CH    = CH_BITS'(6);
   localparam logic [RUN_BITS-1:0]    RUN_MAX      = {RUN_BITS{1'b1}};

   // item modes
   localparam logic [1:0] MODE_CAL_START  = 2'd0;
   localparam logic [1:0] MODE_CAL_SAMPLE = 2'd1;
   localparam logic [1:0] MODE_MEASURE    = 2'd2;
   localparam logic [1:0] MODE_UNUSED     = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DARK_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EDGE_THRESHOLD   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_THRESHOLD = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FAULT_LIMIT      = 2'd3;

   typedef struct packed {
      logic [1:0]             mode;
      logic [CH_BITS-1:0]     channel;
      logic [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [ERR_BITS-1:0] position_error;
      logic                       crossing_seen;
      logic                       all_dark;
      logic                       fault;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic                  step;
      logic [CH_BITS-1:0]    index;
      logic [RATIO_BITS-1:0] ratio;
   } scan_ctrl_type;

   typedef struct packed {
      logic signed [ERR_BITS-1:0] position_error;
      logic                       crossing_seen;
      logic                       all_dark;
   } scan_res_type;

   // weight in tenths, growing outward from the centre channel
   function automatic logic [WEIGHT_BITS-1:0] channel_weight(input logic [CH_BITS-1:0] ch);
      logic [WEIGHT_BITS-1:0] w;
      case (ch)
         4'd0, 4'd12: w = 5'd30;
         4'd1, 4'd11: w = 5'd26;
         4'd2, 4'd10: w = 5'd22;
         4'd3, 4'd9:  w = 5'd18;
         4'd4, 4'd8:  w = 5'd14;
         4'd5, 4'd7:  w = 5'd10;
         default:     w = 5'd0;
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/line_sensor_array_position.sv
// top level of the line sensor array: calibration store, ratio sequencer and result register
//
//   channel  direction  ports                            carries
//   req      in         req_valid req_ready req_data     one channel sample item
//   rsp      out        rsp_valid rsp_ready rsp_data     scan result item
//   csr      in         csr_write_en csr_index csr_wdata threshold and limit writes
//
// calibration items and ignored items are handled in ST_IDLE; a measure item passes through
// ST_MUL and ST_DIV, where the shared restoring divider runs its ten steps.
// the last channel adds a sweep over the stored ratios in ST_SCAN, then ST_EMIT to emit.
// a scan result waits in the output register; a further result waits until it is taken.
// synchronous reset clears control state and the calibration levels and loads the default thresholds and limit.
module line_sensor_array_position
   import lsap_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   req_type                  item_ff, item_in;
   logic [SAMPLE_BITS-1:0]   min_ff [SENSOR_COUNT];
   logic [SAMPLE_BITS-1:0]   min_in [SENSOR_COUNT];
   logic [SAMPLE_BITS-1:0]   max_ff [SENSOR_COUNT];
   logic [SAMPLE_BITS-1:0]   max_in [SENSOR_COUNT];
   logic [RATIO_BITS-1:0]    ratio_ff [SENSOR_COUNT];
   logic                     zero_span_ff, zero_span_in;
   logic [CH_BITS-1:0]       sweep_ff, sweep_in;
   logic [CSR_DATA_BITS-1:0] dark_thr_ff, edge_thr_ff, center_thr_ff;
   logic [RUN_BITS-1:0]      fault_limit_ff;
   logic [RUN_BITS-1:0]      dark_run_ff, dark_run_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic                     ch_ok;
   logic [SAMPLE_BITS-1:0]   lo, hi, clamped, diff, span;
   logic [PROD_BITS-1:0]     product;
   logic                     div_start, div_done;
   logic [RATIO_BITS-1:0]    quotient;
   logic                     ratio_we;
   logic [RATIO_BITS-1:0]    ratio_wdata;
   logic                     emit;
   scan_ctrl_type            scan_ctrl;
   scan_res_type             scan_res;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid & req_ready;
   assign ch_ok     = req_data.channel < CH_BITS'(SENSOR_COUNT);

   // ratio numerator: clamp into the span, then scale by one thousand
   always_comb begin
      lo      = min_ff[item_ff.channel];
      hi      = max_ff[item_ff.channel];
      clamped = item_ff.sample;
      if (clamped > hi) begin
         clamped = hi;
      end
      if (clamped < lo) begin
         clamped = lo;
      end
      diff    = clamped - lo;
      span    = hi - lo;
      product = PROD_BITS'(diff * RATIO_ONE);
   end

   assign div_start = state_ff == ST_MUL;

   lsap_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (product),
      .divisor   (span),
      .done      (div_done),
      .quotient  (quotient)
   );

   assign ratio_we    = (state_ff == ST_DIV) && div_done;
   assign ratio_wdata = zero_span_ff ? '0 : quotient;
   assign emit        = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      scan_ctrl.start = ratio_we && (item_ff.channel == LAST_CHANNEL);
      scan_ctrl.step  = state_ff == ST_SCAN;
      scan_ctrl.index = sweep_ff;
      scan_ctrl.ratio = ratio_ff[sweep_ff];
   end

   lsap_scan u_scan (
      .clock            (clock),
      .ctrl             (scan_ctrl),
      .dark_threshold   (dark_thr_ff),
      .edge_threshold   (edge_thr_ff),
      .center_threshold (center_thr_ff),
      .res              (scan_res)
   );

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      zero_span_in = zero_span_ff;
      sweep_in     = sweep_ff;
      dark_run_in  = dark_run_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = req_data;
               case (req_data.mode)
                  MODE_CAL_START: begin
                     for (int k = 0; k < SENSOR_COUNT; k++) begin
                        min_in[k] = FULL_SCALE;
                        max_in[k] = '0;
                     end
                  end
                  MODE_CAL_SAMPLE: begin
                     if (ch_ok) begin
                        if (req_data.sample > max_ff[req_data.channel]) begin
                           max_in[req_data.channel] = req_data.sample;
                        end
                        if (req_data.sample < min_ff[req_data.channel]) begin
                           min_in[req_data.channel] = req_data.sample;
                        end
                     end
                  end
                  MODE_MEASURE: begin
                     if (ch_ok) begin
                        state_in = ST_MUL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            zero_span_in = hi <= lo;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if (item_ff.channel == LAST_CHANNEL) begin
                  sweep_in = '0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_CHANNEL) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               if (scan_res.all_dark) begin
                  if (dark_run_ff != RUN_MAX) begin
                     dark_run_in = dark_run_ff + 1'b1;
                  end
               end else begin
                  dark_run_in = '0;
               end
               rsp_data_in.position_error = scan_res.position_error;
               rsp_data_in.crossing_seen  = scan_res.crossing_seen;
               rsp_data_in.all_dark       = scan_res.all_dark;
               rsp_data_in.fault          = dark_run_in > fault_limit_ff;
               rsp_valid_in               = 1'b1;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      zero_span_ff <= zero_span_in;
      sweep_ff     <= sweep_in;
      rsp_data_ff  <= rsp_data_in;
      if (ratio_we) begin
         ratio_ff[item_ff.channel] <= ratio_wdata;
      end
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         dark_run_ff    <= '0;
         dark_thr_ff    <= CSR_DATA_BITS'(600);
         edge_thr_ff    <= CSR_DATA_BITS'(500);
         center_thr_ff  <= CSR_DATA_BITS'(800);
         fault_limit_ff <= RUN_BITS'(110);
         for (int k = 0; k < SENSOR_COUNT; k++) begin
            min_ff[k] <= '0;
            max_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dark_run_ff  <= dark_run_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_DARK_THRESHOLD:   dark_thr_ff    <= csr_wdata;
               CSR_EDGE_THRESHOLD:   edge_thr_ff    <= csr_wdata;
               CSR_CENTER_THRESHOLD: center_thr_ff  <= csr_wdata;
               CSR_FAULT_LIMIT:      fault_limit_ff <= csr_wdata[RUN_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/lsap_divider.sv
// restoring divider, one quotient bit per cycle, for the channel ratio
module lsap_divider
   import lsap_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [PROD_BITS-1:0]   numerator,
   input  logic [SAMPLE_BITS-1:0] divisor,
   output logic                   done,
   output logic [RATIO_BITS-1:0]  quotient
);

   logic [SAMPLE_BITS-1:0]  rem_ff, rem_in;
   logic [RATIO_BITS-1:0]   low_ff, low_in;
   logic [SAMPLE_BITS-1:0]  divisor_ff, divisor_in;
   logic [DIV_CNT_BITS-1:0] count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [SAMPLE_BITS:0]    trial;
   logic [SAMPLE_BITS:0]    diff;
   logic                    ge;

   // quotient is below 1024, so the top bits of the numerator are already below the divisor
   always_comb begin
      trial      = {rem_ff, low_ff[RATIO_BITS-1]};
      ge         = trial >= {1'b0, divisor_ff};
      diff       = trial - {1'b0, divisor_ff};
      rem_in     = rem_ff;
      low_in     = low_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = numerator[PROD_BITS-1:RATIO_BITS];
         low_in     = numerator[RATIO_BITS-1:0];
         divisor_in = divisor;
         count_in   = DIV_CNT_BITS'(RATIO_BITS);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
         low_in   = {low_ff[RATIO_BITS-2:0], ge};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

// File: rtl/core/lsap_scan.sv
// end-of-scan sweep: weighted position sum, dark and crossing flags, one channel a cycle
module lsap_scan
   import lsap_pkg::*;
(
   input  logic                     clock,
   input  scan_ctrl_type            ctrl,
   input  logic [CSR_DATA_BITS-1:0] dark_threshold,
   input  logic [CSR_DATA_BITS-1:0] edge_threshold,
   input  logic [CSR_DATA_BITS-1:0] center_threshold,
   output scan_res_type             res
);

   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic                       dark_ff, dark_in;
   logic                       edge_l_ff, edge_l_in;
   logic                       edge_r_ff, edge_r_in;
   logic                       center_ff, center_in;
   logic [WPROD_BITS-1:0]      wprod;
   logic signed [ERR_BITS-1:0] term;
   logic                       at_edge;

   always_comb begin
      wprod     = WPROD_BITS'(ctrl.ratio * channel_weight(ctrl.index));
      term      = $signed(ERR_BITS'(wprod));
      at_edge   = ctrl.ratio <= edge_threshold;
      err_in    = err_ff;
      dark_in   = dark_ff;
      edge_l_in = edge_l_ff;
      edge_r_in = edge_r_ff;
      center_in = center_ff;
      if (ctrl.start) begin
         err_in    = '0;
         dark_in   = 1'b1;
         edge_l_in = 1'b0;
         edge_r_in = 1'b0;
         center_in = 1'b0;
      end else if (ctrl.step) begin
         // left side adds, right side subtracts, centre has no weight
         if (ctrl.index < CENTER_CH) begin
            err_in = err_ff + term;
         end else if (ctrl.index > CENTER_CH) begin
            err_in = err_ff - term;
         end
         dark_in = dark_ff & (ctrl.ratio >= dark_threshold);
         if ((ctrl.index == 4'd0 || ctrl.index == 4'd1) && at_edge) begin
            edge_l_in = 1'b1;
         end
         if ((ctrl.index == 4'd11 || ctrl.index == LAST_CHANNEL) && at_edge) begin
            edge_r_in = 1'b1;
         end
         if (ctrl.index == CENTER_CH) begin
            center_in = ctrl.ratio <= center_threshold;
         end
      end
   end

   always_ff @(posedge clock) begin
      err_ff    <= err_in;
      dark_ff   <= dark_in;
      edge_l_ff <= edge_l_in;
      edge_r_ff <= edge_r_in;
      center_ff <= center_in;
   end

   assign res.position_error = err_ff;
   assign res.crossing_seen  = edge_l_ff & edge_r_ff & center_ff;
   assign res.all_dark       = dark_ff;

endmodule
